// ===== rtl/a64ls_pkg.sv =====
// Package: shared types and constants of the A64 load/store unit.
`timescale 1ns / 1ps
package a64ls_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ADDR  = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_LDATA = 5'b01000,
        ST_CLEAR = 5'b10000
    } t_state;

    // Transaction kinds.
    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_REG_WR = 2'd1;
    localparam logic [1:0] ACT_MEM_WR = 2'd2;

    // Register number field width and the zero register.
    localparam int         REG_IDX_W = 5;
    localparam logic [4:0] REG_ZERO  = 5'd31;

    // Instruction bit positions.
    localparam int BIT_SDT   = 31;
    localparam int BIT_SF    = 30;
    localparam int BIT_UIMM  = 24;
    localparam int BIT_LOAD  = 22;
    localparam int BIT_ROFF  = 21;
    localparam int BIT_PRE   = 11;

    // Byte lanes of one data memory row.
    localparam int LANES = 8;

    // Decoded view of the instruction held in the sequencer.
    typedef struct packed {
        logic [4:0] rt;
        logic [4:0] xn;
        logic [4:0] xm;
        logic       sf;
        logic       sdt;
        logic       load;
        logic       uimm;
        logic       roff;
        logic       pre;
        logic       post;
    } t_dec;

endpackage

// ===== rtl/a64ls_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module a64ls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/arm64_load_store_unit.sv =====
// Top level: A64 single-register load/store unit with register file and data memory.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ---------------------------------------------
//  command   in         start & !busy         i_action, i_instr_word, i_pc, i_host_index,
//                                             i_host_value
//  result    out        o_done (1-cycle)      o_eff_address, o_loaded_value, o_target_reg,
//                                             o_was_load, o_did_writeback
//
//  Steps per transaction (busy is high for all but the accept cycle):
//    host register/memory write and unused action: accept only, no busy time.
//    store: accept, register read + address, memory write.
//    load:  accept, register read + address, memory read, data return.
//  The result strobe comes in the cycle after the last of these; the next transaction
//  may be accepted in that same cycle. The registered reads of the register file
//  and of the data memory set these steps.
//  Reset: the register file is zero through per-entry valid bits; the data memory
//  is cleared by a sweep of all MEM_BYTES/8 rows (one row of 8 bytes per cycle) during
//  which busy is high. The receiver cannot stall the result.
//  MEM_BYTES must be a power of two.
//
module arm64_load_store_unit #(
    parameter int MEM_BYTES = 2097152,
    parameter int REG_COUNT = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_instr_word,
    input  logic [63:0] i_pc,
    input  logic [20:0] i_host_index,
    input  logic [63:0] i_host_value,
    output logic        o_done,
    output logic [63:0] o_eff_address,
    output logic [63:0] o_loaded_value,
    output logic [4:0]  o_target_reg,
    output logic        o_was_load,
    output logic        o_did_writeback
);

    import a64ls_pkg::*;

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int ROWS  = MEM_BYTES / LANES;
    localparam int ROW_W = AW - 3;
    localparam int RA_W  = $clog2(REG_COUNT);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_clr_row;
    logic [REG_COUNT-1:0] r_rf_valid;
    logic [31:0]         r_instr;
    logic [63:0]         r_pc;
    logic [63:0]         r_addr;
    logic [63:0]         r_wbval;
    logic                r_wb;

    logic                r_done;
    logic [63:0]         r_eff;
    logic [63:0]         r_lval;
    logic [4:0]          r_treg;
    logic                r_was_load;
    logic                r_did_wb;

    logic                w_accept;
    t_dec                w_dec;
    logic [REG_COUNT:0]  w_live;     // valid bits, zero register always dead

    // register file ports (two copies, written together)
    logic [RA_W-1:0]     w_rf_raddr_a, w_rf_raddr_b, w_rf_waddr;
    logic                w_rf_we;
    logic [63:0]         w_rf_wdata, w_rf_q_a, w_rf_q_b;

    // data memory banks
    logic [ROW_W-1:0]    w_bank_addr [LANES];
    logic [LANES-1:0]    w_bank_we;
    logic [7:0]          w_bank_wd [LANES];
    logic [7:0]          w_bank_q  [LANES];

    logic [63:0]         w_xn_val, w_xm_val, w_rt_val;
    logic [63:0]         w_base, w_off, w_sum, w_addr;
    logic                w_wb;
    logic [63:0]         w_ld_val;
    logic [AW-1:0]       w_host_baddr;
    logic                w_host_reg_ok;
    logic [2:0]          w_a0;
    logic [ROW_W-1:0]    w_row0;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // ------------------------------------------------------------------
    // Decode of the held instruction
    // ------------------------------------------------------------------
    always_comb begin
        w_dec.rt   = r_instr[4:0];
        w_dec.xn   = r_instr[9:5];
        w_dec.xm   = r_instr[20:16];
        w_dec.sf   = r_instr[BIT_SF];
        w_dec.sdt  = r_instr[BIT_SDT];
        w_dec.load = !r_instr[BIT_SDT] || r_instr[BIT_LOAD];
        w_dec.uimm = r_instr[BIT_UIMM];
        w_dec.roff = !r_instr[BIT_UIMM] && r_instr[BIT_ROFF];
        w_dec.pre  = !r_instr[BIT_UIMM] && !r_instr[BIT_ROFF] && r_instr[BIT_PRE];
        w_dec.post = !r_instr[BIT_UIMM] && !r_instr[BIT_ROFF] && !r_instr[BIT_PRE];
    end

    assign w_live = {1'b0, r_rf_valid};

    // Register reads: entries never written, and the zero register, read as zero.
    assign w_xn_val = w_live[w_dec.xn] ? w_rf_q_a : 64'd0;
    assign w_xm_val = w_live[w_dec.xm] ? w_rf_q_b : 64'd0;
    // Store data: forward the base update when rt is the written-back base.
    assign w_rt_val = (r_wb && (w_dec.rt == w_dec.xn)) ? r_wbval :
                      (w_live[w_dec.rt] ? w_rf_q_a : 64'd0);

    // ------------------------------------------------------------------
    // Address generation (one adder serves every mode)
    // ------------------------------------------------------------------
    always_comb begin
        w_base = w_dec.sdt ? w_xn_val : r_pc;
        if (!w_dec.sdt) begin
            w_off = {{43{r_instr[23]}}, r_instr[23:5], 2'b00};
        end else if (w_dec.uimm) begin
            w_off = w_dec.sf ? {49'd0, r_instr[21:10], 3'b000}
                             : {50'd0, r_instr[21:10], 2'b00};
        end else if (w_dec.roff) begin
            w_off = w_xm_val;
        end else begin
            w_off = {{55{r_instr[20]}}, r_instr[20:12]};
        end
        w_sum  = w_base + w_off;
        w_addr = (w_dec.sdt && w_dec.post) ? w_base : w_sum;
        w_wb   = w_dec.sdt && (w_dec.pre || w_dec.post) && (w_dec.xn != REG_ZERO);
    end

    // ------------------------------------------------------------------
    // Register file write port
    // ------------------------------------------------------------------
    assign w_host_reg_ok = (i_host_index < 21'(REG_COUNT));

    always_comb begin
        w_rf_we    = 1'b0;
        w_rf_waddr = RA_W'(w_dec.rt);
        w_rf_wdata = w_ld_val;
        unique case (r_state) inside
            ST_IDLE: begin
                if (w_accept && (i_action == ACT_REG_WR) && w_host_reg_ok) begin
                    w_rf_we    = 1'b1;
                    w_rf_waddr = RA_W'(i_host_index);
                    w_rf_wdata = i_host_value;
                end
            end
            ST_ADDR: begin
                w_rf_we    = w_wb;
                w_rf_waddr = RA_W'(w_dec.xn);
                w_rf_wdata = w_sum;
            end
            ST_LDATA: begin
                w_rf_we = (w_dec.rt != REG_ZERO);
            end
            ST_ACC, ST_CLEAR: begin
                w_rf_we = 1'b0;
            end
            default: begin
                w_rf_we = 1'b0;
            end
        endcase
    end

    // Port A: base at accept, then rt for a store. Port B: offset register.
    assign w_rf_raddr_a = (r_state == ST_IDLE) ? RA_W'(i_instr_word[9:5])
                                               : RA_W'(w_dec.rt);
    assign w_rf_raddr_b = RA_W'(i_instr_word[20:16]);

    a64ls_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (w_rf_we),
        .i_waddr (w_rf_waddr),
        .i_wdata (w_rf_wdata),
        .i_raddr (w_rf_raddr_a),
        .o_rdata (w_rf_q_a)
    );

    a64ls_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (w_rf_we),
        .i_waddr (w_rf_waddr),
        .i_wdata (w_rf_wdata),
        .i_raddr (w_rf_raddr_b),
        .o_rdata (w_rf_q_b)
    );

    // ------------------------------------------------------------------
    // Data memory: 8 byte banks, byte a lives in bank a[2:0], row a>>3.
    // A misaligned access spills into the next row for banks below a[2:0].
    // ------------------------------------------------------------------
    assign w_a0         = r_addr[2:0];
    assign w_row0       = r_addr[AW-1:3];
    assign w_host_baddr = AW'(i_host_index);

    always_comb begin
        logic [2:0] lane_k;
        for (int b = 0; b < LANES; b++) begin
            lane_k         = 3'(b) - w_a0;
            w_bank_addr[b] = w_row0 + ROW_W'(3'(b) < w_a0);
            w_bank_we[b]   = 1'b0;
            w_bank_wd[b]   = w_rt_val[{lane_k, 3'b000} +: 8];
            if (r_state == ST_CLEAR) begin
                w_bank_addr[b] = r_clr_row;
                w_bank_we[b]   = 1'b1;
                w_bank_wd[b]   = 8'd0;
            end else if (r_state == ST_IDLE) begin
                w_bank_addr[b] = w_host_baddr[AW-1:3];
                w_bank_we[b]   = w_accept && (i_action == ACT_MEM_WR)
                                 && (w_host_baddr[2:0] == 3'(b));
                w_bank_wd[b]   = i_host_value[7:0];
            end else if (r_state == ST_ACC) begin
                w_bank_we[b] = !w_dec.load && (w_dec.sf || !lane_k[2]);
            end
        end
    end

    for (genvar gb = 0; gb < LANES; gb++) begin : g_bank
        a64ls_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_bank_we[gb]),
            .i_waddr (w_bank_addr[gb]),
            .i_wdata (w_bank_wd[gb]),
            .i_raddr (w_bank_addr[gb]),
            .o_rdata (w_bank_q[gb])
        );
    end

    // Rotate bank data back into byte order; 32-bit loads zero-extend.
    always_comb begin
        logic [2:0] idx;
        for (int k = 0; k < LANES; k++) begin
            idx                = w_a0 + 3'(k);
            w_ld_val[k*8 +: 8] = w_bank_q[idx];
        end
        if (!w_dec.sf) begin
            w_ld_val[63:32] = 32'd0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_action == ACT_EXEC)) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR:  n_state = ST_ACC;
            ST_ACC:   n_state = w_dec.load ? ST_LDATA : ST_IDLE;
            ST_LDATA: n_state = ST_IDLE;
            ST_CLEAR: begin
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_row  <= '0;
            r_rf_valid <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
            if (w_rf_we) begin
                r_rf_valid[w_rf_waddr] <= 1'b1;
            end
            r_done <= (w_accept && (i_action != ACT_EXEC))
                      || ((r_state == ST_ACC) && !w_dec.load)
                      || (r_state == ST_LDATA);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_instr <= i_instr_word;
            r_pc    <= i_pc;
        end
        if (r_state == ST_ADDR) begin
            r_addr  <= w_addr;
            r_wbval <= w_sum;
            r_wb    <= w_wb;
        end
        if (w_accept) begin
            r_eff      <= 64'd0;
            r_lval     <= 64'd0;
            r_treg     <= 5'd0;
            r_was_load <= 1'b0;
            r_did_wb   <= 1'b0;
        end else if (((r_state == ST_ACC) && !w_dec.load) || (r_state == ST_LDATA)) begin
            r_eff      <= r_addr;
            r_lval     <= w_dec.load ? w_ld_val : 64'd0;
            r_treg     <= w_dec.rt;
            r_was_load <= w_dec.load;
            r_did_wb   <= r_wb;
        end
    end

    assign o_done          = r_done;
    assign o_eff_address   = r_eff;
    assign o_loaded_value  = r_lval;
    assign o_target_reg    = r_treg;
    assign o_was_load      = r_was_load;
    assign o_did_writeback = r_did_wb;

endmodule
